@@ design/ilws_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the card list with sort.
package ilws_pkg;

  localparam int CapacityDefault = 64;
  localparam int CardW = 6;
  localparam int OpW = 3;
  localparam int PosW = 7;
  localparam int RankW = 4;
  localparam int SuitW = 2;
  localparam int StatusW = 2;
  localparam int CountOutW = 7;
  localparam int InDataW = 16;
  localparam int OutDataW = 16;

  localparam logic [OpW-1:0] OP_PUSH = 3'd0;
  localparam logic [OpW-1:0] OP_POP = 3'd1;
  localparam logic [OpW-1:0] OP_INSERT = 3'd2;
  localparam logic [OpW-1:0] OP_REMOVE = 3'd3;
  localparam logic [OpW-1:0] OP_SORT = 3'd4;

  localparam logic [StatusW-1:0] ST_OK = 2'd0;
  localparam logic [StatusW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatusW-1:0] ST_RANGE = 2'd2;
  localparam logic [StatusW-1:0] ST_FULL = 2'd3;

  typedef logic [CardW-1:0] card_t;

  typedef enum logic [1:0] {
    CMD_HOLD,
    CMD_INS,
    CMD_DEL,
    CMD_SORT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t cmd;
    logic      phase;
    card_t     card;
  } cell_ctrl_t;

endpackage

@@ design/ilws_cell.sv @@
`timescale 1ns / 1ps
// One list slot: holds a card and moves it to or from its neighbors.
module ilws_cell #(
  parameter int CW = 7,
  parameter int IDX = 0
) (
  input  logic                clk,
  input  ilws_pkg::cell_ctrl_t ctrl,
  input  logic [CW-1:0]       pos,
  input  logic [CW-1:0]       count,
  input  ilws_pkg::card_t     left_i,
  input  ilws_pkg::card_t     right_i,
  output ilws_pkg::card_t     q
);
  import ilws_pkg::*;

  localparam logic [CW-1:0] MyIdx = CW'(IDX);
  localparam logic [CW-1:0] NextIdx = CW'(IDX + 1);
  localparam logic MyParity = 1'((IDX % 2) == 1);

  card_t data_r;
  card_t data_nxt;

  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.cmd)
      CMD_INS: begin
        if (MyIdx == pos) begin
          data_nxt = ctrl.card;
        end else if (MyIdx > pos) begin
          data_nxt = left_i;
        end
      end
      CMD_DEL: begin
        if (MyIdx >= pos) begin
          data_nxt = right_i;
        end
      end
      CMD_SORT: begin
        if (MyParity == ctrl.phase) begin
          if (NextIdx < count && right_i < data_r) begin
            data_nxt = right_i;
          end
        end else if (IDX > 0 && MyIdx < count && left_i > data_r) begin
          data_nxt = left_i;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign q = data_r;

endmodule

@@ design/indexed_list_with_sort_top.sv @@
`timescale 1ns / 1ps
// Top level of the card list: command decode, count, sort sequencing and the row of cells.
//
// An ordered list of up to CAPACITY cards held in a row of cells, one card per cell.
// Push, pop, insert and remove complete in the cycle the transaction is accepted, so
// they sustain one transaction per cycle while the result register drains. Insert and
// remove shift every later cell by one place at once. Sort runs an odd-even
// transposition pass in which every cell compares with a neighbor each cycle; after the
// transaction is accepted the input is held off until the passes are done, and the result
// is loaded into the output register once the last pass is done and that register is
// free. Contents of slots never written are undefined; no clearing pass is run after
// reset.
module indexed_list_with_sort_top #(
  parameter int CAPACITY = ilws_pkg::CapacityDefault
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // opcode[2:0], position[9:3], card_rank[13:10], card_suit[15:14]
  input  logic [ilws_pkg::InDataW-1:0]  in_tdata,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // status[1:0], card_valid[2], out_rank[6:3], out_suit[8:7], entry_count[15:9]
  output logic [ilws_pkg::OutDataW-1:0] out_tdata
);
  import ilws_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int MW = (CW > PosW) ? CW : PosW;
  localparam logic [MW-1:0] CapW = MW'(CAPACITY);

  typedef enum logic {
    S_IDLE,
    S_SORT
  } state_t;

  state_t state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] sort_cnt_r;
  logic out_valid_r;
  logic [StatusW-1:0] out_status_r;
  logic out_card_valid_r;
  card_t out_card_r;
  logic [CountOutW-1:0] out_count_r;

  logic [OpW-1:0] in_opcode;
  logic [PosW-1:0] in_position;
  logic [RankW-1:0] in_card_rank;
  logic [SuitW-1:0] in_card_suit;

  card_t cell_q [CAPACITY];
  cell_ctrl_t ctrl;
  logic [CW-1:0] cell_pos;

  logic accept;
  logic out_free;
  logic [MW-1:0] pos_w;
  logic [MW-1:0] cnt_w;
  logic [MW-1:0] take_idx;
  logic [StatusW-1:0] res_status;
  logic res_valid;
  logic [CW-1:0] count_nxt;
  logic start_sort;
  logic sort_last;
  logic [MW-1:0] sort_cnt_w;
  logic [MW-1:0] count_out_w;

  assign in_opcode = in_tdata[2:0];
  assign in_position = in_tdata[9:3];
  assign in_card_rank = in_tdata[13:10];
  assign in_card_suit = in_tdata[15:14];

  assign out_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE) && out_free;
  assign accept = in_tvalid && in_tready;

  assign pos_w = MW'(in_position);
  assign cnt_w = MW'(count_r);
  assign sort_cnt_w = MW'(sort_cnt_r) + MW'(1);
  assign sort_last = sort_cnt_w >= cnt_w;

  always_comb begin
    res_status = ST_OK;
    res_valid = 1'b0;
    count_nxt = count_r;
    start_sort = 1'b0;
    take_idx = pos_w;
    ctrl.cmd = CMD_HOLD;
    ctrl.phase = sort_cnt_r[0];
    ctrl.card = {in_card_rank, in_card_suit};
    cell_pos = CW'(pos_w);
    unique case (in_opcode)
      OP_PUSH: begin
        cell_pos = count_r;
        if (cnt_w >= CapW) begin
          res_status = ST_FULL;
        end else begin
          ctrl.cmd = CMD_INS;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_POP: begin
        take_idx = cnt_w - MW'(1);
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else begin
          res_valid = 1'b1;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_INSERT: begin
        if (pos_w > cnt_w) begin
          res_status = ST_RANGE;
        end else if (cnt_w >= CapW) begin
          res_status = ST_FULL;
        end else begin
          ctrl.cmd = CMD_INS;
          count_nxt = count_r + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (count_r == '0) begin
          res_status = ST_EMPTY;
        end else if (pos_w >= cnt_w) begin
          res_status = ST_RANGE;
        end else begin
          res_valid = 1'b1;
          ctrl.cmd = CMD_DEL;
          count_nxt = count_r - CW'(1);
        end
      end
      OP_SORT: begin
        start_sort = 1'b1;
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    if (!accept) begin
      ctrl.cmd = CMD_HOLD;
    end
    if (state_r == S_SORT) begin
      ctrl.cmd = CMD_SORT;
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    card_t left_d;
    card_t right_d;
    if (g == 0) begin : g_first
      assign left_d = '0;
    end else begin : g_left
      assign left_d = cell_q[g-1];
    end
    if (g == CAPACITY - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_right
      assign right_d = cell_q[g+1];
    end
    ilws_cell #(
      .CW (CW),
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .ctrl   (ctrl),
      .pos    (cell_pos),
      .count  (count_r),
      .left_i (left_d),
      .right_i(right_d),
      .q      (cell_q[g])
    );
  end

  assign count_out_w = MW'(count_nxt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      sort_cnt_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            count_r <= count_nxt;
            if (start_sort) begin
              state_r <= S_SORT;
              sort_cnt_r <= '0;
            end else begin
              out_valid_r <= 1'b1;
              out_status_r <= res_status;
              out_card_valid_r <= res_valid;
              out_card_r <= res_valid ? cell_q[take_idx[AW-1:0]] : '0;
              out_count_r <= count_out_w[CountOutW-1:0];
            end
          end
        end
        S_SORT: begin
          if (!sort_last) begin
            sort_cnt_r <= sort_cnt_r + CW'(1);
          end else if (out_free) begin
            state_r <= S_IDLE;
            out_valid_r <= 1'b1;
            out_status_r <= ST_OK;
            out_card_valid_r <= 1'b0;
            out_card_r <= '0;
            out_count_r <= cnt_w[CountOutW-1:0];
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata = {out_count_r, out_card_r[SuitW-1:0], out_card_r[CardW-1:SuitW],
                      out_card_valid_r, out_status_r};

endmodule
